/* hw/rtl/utf8v_pkg.sv */
package utf8v_pkg;

	// Byte codes that mark lead bytes and control characters
	localparam logic [7:0] C0_LIMIT  = 8'h20;
	localparam logic [7:0] DEL_CHAR  = 8'h7f;
	localparam logic [7:0] C1_LOW    = 8'h80;
	localparam logic [7:0] C1_HIGH   = 8'h9f;
	localparam logic [7:0] ASCII_TOP = 8'h7f;
	localparam logic [7:0] LEAD2_LOW = 8'hc2;
	localparam logic [7:0] LEAD2_TOP = 8'hdf;
	localparam logic [7:0] LEAD3_LOW = 8'he0;
	localparam logic [7:0] LEAD3_TOP = 8'hef;
	localparam logic [7:0] LEAD4_LOW = 8'hf0;
	localparam logic [7:0] LEAD4_TOP = 8'hf4;

	// Code point limits
	localparam int unsigned POINT_W = 21;
	localparam logic [POINT_W-1:0] MIN_THREE  = 21'h000800;
	localparam logic [POINT_W-1:0] MIN_FOUR   = 21'h010000;
	localparam logic [POINT_W-1:0] SURR_LOW   = 21'h00d800;
	localparam logic [POINT_W-1:0] SURR_HIGH  = 21'h00dfff;
	localparam logic [POINT_W-1:0] POINT_MAX  = 21'h10ffff;

	// Sequence lengths
	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_string;
	} item_t;

	typedef struct packed {
		logic utf8_ok;
		logic control_found;
	} verdict_t;

endpackage

/* hw/rtl/utf8_text_validator_core.sv */
// UTF-8 text validator with control-character detection.
// Input channel: in_valid / in_stall carry one request per string byte
// (data_byte, has_byte, end_of_string). An item with has_byte low and
// end_of_string high ends a string without a byte; one with both low is idle.
// Output channel: out_valid / out_stall carry one verdict (utf8_ok,
// control_found) for each item marked end_of_string; other items give none.
// Throughput: one item per cycle while in_stall is low, set by the single
// scan stage that updates the decoder state once per byte.
// An accepted request is held in the input register, where the scan stage
// works on it; its verdict is then loaded into the result register.
// Reset (arst_n low) empties the input and output registers and clears the
// decoder state; each verdict also clears it for the next string.
// When out_stall holds a verdict, byte items keep flowing; only an end item
// waits in the input register, and in_stall rises until the verdict is taken.
module utf8_text_validator_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       utf8_ok,
	output logic       control_found
);
	import utf8v_pkg::*;

	logic     valid_s1;
	item_t    item_s1;
	logic     out_free;
	logic     s1_go;
	verdict_t verdict;
	logic     out_valid_q;
	verdict_t verdict_q;

	// Move the held request on unless its verdict has nowhere to go
	assign out_free = !out_valid_q || !out_stall;
	assign s1_go    = valid_s1 && (!item_s1.end_of_string || out_free);
	assign in_stall = valid_s1 && !s1_go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.data_byte     <= data_byte;
			item_s1.has_byte      <= has_byte;
			item_s1.end_of_string <= end_of_string;
		end
	end

	utf8v_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_go),
		.item    (item_s1),
		.verdict (verdict)
	);

	// Result register: load a verdict, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && item_s1.end_of_string) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.end_of_string) begin
			verdict_q <= verdict;
		end
	end

	assign out_valid     = out_valid_q;
	assign utf8_ok       = verdict_q.utf8_ok;
	assign control_found = verdict_q.control_found;

endmodule

/* hw/rtl/utf8v_scan.sv */
module utf8v_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  utf8v_pkg::item_t  item,
	output utf8v_pkg::verdict_t verdict
);
	import utf8v_pkg::*;

	logic [1:0]         pend_q, pend_n;
	logic [2:0]         len_q, len_n;
	logic [POINT_W-1:0] point_q, point_n;
	logic               err_q, err_n;
	logic               ctrl_q, ctrl_n;
	logic               c2_q, c2_n;
	logic [7:0]         b;

	assign b = item.data_byte;

	// Work out the state after this byte
	always_comb begin
		pend_n  = pend_q;
		len_n   = len_q;
		point_n = point_q;
		err_n   = err_q;
		ctrl_n  = ctrl_q;
		c2_n    = c2_q;
		if (item.has_byte) begin
			// flag control characters on the raw byte stream
			if (b < C0_LIMIT || b == DEL_CHAR)
				ctrl_n = 1'b1;
			if (c2_q && b >= C1_LOW && b <= C1_HIGH)
				ctrl_n = 1'b1;
			c2_n = (b == LEAD2_LOW);
			// track the encoding until the first error
			if (!err_q) begin
				if (pend_q == 2'd0) begin
					if (b <= ASCII_TOP) begin
						len_n   = LEN_ONE;
						point_n = {13'd0, b};
					end else if (b >= LEAD2_LOW && b <= LEAD2_TOP) begin
						len_n   = LEN_TWO;
						point_n = {16'd0, b[4:0]};
						pend_n  = 2'd1;
					end else if (b >= LEAD3_LOW && b <= LEAD3_TOP) begin
						len_n   = LEN_THREE;
						point_n = {17'd0, b[3:0]};
						pend_n  = 2'd2;
					end else if (b >= LEAD4_LOW && b <= LEAD4_TOP) begin
						len_n   = LEN_FOUR;
						point_n = {18'd0, b[2:0]};
						pend_n  = 2'd3;
					end else begin
						err_n = 1'b1;
					end
				end else if (b[7:6] != 2'b10) begin
					err_n  = 1'b1;
					pend_n = 2'd0;
				end else begin
					point_n = {point_q[POINT_W-7:0], b[5:0]};
					pend_n  = pend_q - 2'd1;
					// check the finished code point
					if (pend_n == 2'd0) begin
						if ((len_q == LEN_THREE && point_n < MIN_THREE) ||
						    (len_q == LEN_FOUR && point_n < MIN_FOUR) ||
						    (point_n >= SURR_LOW && point_n <= SURR_HIGH) ||
						    point_n > POINT_MAX)
							err_n = 1'b1;
					end
				end
			end
		end
	end

	assign verdict.utf8_ok       = !err_n && (pend_n == 2'd0);
	assign verdict.control_found = ctrl_n;

	// Advance the state; clear it at the end of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			len_q   <= '0;
			point_q <= '0;
			err_q   <= 1'b0;
			ctrl_q  <= 1'b0;
			c2_q    <= 1'b0;
		end else if (step) begin
			if (item.end_of_string) begin
				pend_q  <= '0;
				len_q   <= '0;
				point_q <= '0;
				err_q   <= 1'b0;
				ctrl_q  <= 1'b0;
				c2_q    <= 1'b0;
			end else begin
				pend_q  <= pend_n;
				len_q   <= len_n;
				point_q <= point_n;
				err_q   <= err_n;
				ctrl_q  <= ctrl_n;
				c2_q    <= c2_n;
			end
		end
	end

endmodule
